FILE: src/sts_pkg.sv
package sts_pkg;

  // Status word bit positions
  localparam int unsigned ST_VBLANK    = 0;
  localparam int unsigned ST_HBLANK    = 1;
  localparam int unsigned ST_MATCH     = 2;
  localparam int unsigned ST_VBLANK_IE = 3;
  localparam int unsigned ST_HBLANK_IE = 4;
  localparam int unsigned ST_MATCH_IE  = 5;

  // Bits of the status word that survive a software write
  localparam logic [15:0] KEEP_ON_WRITE = 16'h0007;
  // Line counter after reset (start line with no boot code)
  localparam logic [7:0]  START_LINE    = 8'h7E;

  // Input word kinds
  typedef enum logic {
    KIND_BOUNDARY = 1'b0,
    KIND_WRITE    = 1'b1
  } sts_kind_t;

  typedef struct packed {
    logic [0:0]  kind;
    logic [15:0] write_value;
  } sts_in_t;

  typedef struct packed {
    logic [7:0]  line;
    logic [15:0] status;
    logic        vblank_irq;
    logic        hblank_irq;
    logic        irq_line_match;
    logic        render_line;
    logic        finish_frame;
    logic        dma_hblank;
    logic        dma_vblank;
    logic        frame_start;
    logic        frame_end;
    logic [31:0] frame_number;
  } sts_out_t;

  // Timing state carried from one word to the next
  typedef struct packed {
    logic [7:0]  line_count;
    logic [15:0] status_word;
    logic        in_hblank_phase;
    logic [7:0]  skip_countdown;
    logic [31:0] frames_done;
  } sts_state_t;

endpackage

FILE: src/scanline_timing_status_unit.sv
// An accepted word is held in the input register until the result register is free or
// draining, and then loads the result register, which raises out_valid.
// Throughput: one word per cycle while out_ready stays high; the state update is one
// short pass of logic from the input register, fed back into the timing state registers.
// Reset (rst_n low, synchronous): both stages empty, line 126, status zero,
// next boundary starts hblank, skip countdown, frame count and frames_to_skip zero.
module scanline_timing_status_unit #(
  parameter int unsigned VISIBLE_LINES = 160,
  parameter int unsigned TOTAL_LINES   = 228
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sts_pkg::sts_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sts_pkg::sts_out_t   out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  logic                in_valid_r;
  sts_pkg::sts_in_t    in_word_r;
  logic                out_valid_r;
  sts_pkg::sts_out_t   out_word_r;
  sts_pkg::sts_state_t st_r;
  sts_pkg::sts_state_t st_nxt;
  sts_pkg::sts_out_t   res;
  logic [7:0]          skip_cfg_r;
  logic                adv;

  // Handshake: the input stage moves on when the result register is free or draining
  assign adv       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  sts_step #(
    .VISIBLE_LINES (VISIBLE_LINES),
    .TOTAL_LINES   (TOTAL_LINES)
  ) u_step (
    .st             (st_r),
    .item           (in_word_r),
    .frames_to_skip (skip_cfg_r),
    .st_nxt         (st_nxt),
    .res            (res)
  );

  // Control and timing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
      skip_cfg_r            <= 8'd0;
      st_r.line_count       <= sts_pkg::START_LINE;
      st_r.status_word      <= 16'd0;
      st_r.in_hblank_phase  <= 1'b0;
      st_r.skip_countdown   <= 8'd0;
      st_r.frames_done      <= 32'd0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        skip_cfg_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
    if (adv) begin
      out_word_r <= res;
    end
  end

  // Checks
  a_frame_end_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.frame_end |->
      out_word_r.status[sts_pkg::ST_VBLANK] && out_word_r.line == 8'(VISIBLE_LINES))
    else $error("frame end reported off the first vblank line");

  a_frame_start_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.frame_start |-> out_word_r.line == 8'd0)
    else $error("frame start reported on a non-zero line");

  a_render_has_dma: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.render_line |-> out_word_r.dma_hblank)
    else $error("line render without hblank DMA");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(st_r))
    else $error("timing state changed without an advancing word");

  a_phase_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_word_r.kind == sts_pkg::KIND_BOUNDARY |=>
      st_r.in_hblank_phase != $past(st_r.in_hblank_phase))
    else $error("phase boundary did not toggle the hblank phase");

endmodule

FILE: src/sts_step.sv
module sts_step #(
  parameter int unsigned VISIBLE_LINES = 160,
  parameter int unsigned TOTAL_LINES   = 228
) (
  input  sts_pkg::sts_state_t st,
  input  sts_pkg::sts_in_t    item,
  input  logic [7:0]          frames_to_skip,
  output sts_pkg::sts_state_t st_nxt,
  output sts_pkg::sts_out_t   res
);

  localparam logic [7:0] VIS_LINE  = 8'(VISIBLE_LINES);
  localparam logic [7:0] TOT_LINE  = 8'(TOTAL_LINES);
  localparam logic [7:0] LAST_LINE = 8'(TOTAL_LINES - 1);

  logic [7:0]  line_inc;
  logic [7:0]  line_new;
  logic [15:0] stat;

  // One step of the timing state: status write, hblank start or draw start
  always_comb begin
    st_nxt   = st;
    res      = '0;
    line_inc = st.line_count + 8'd1;
    line_new = (line_inc == TOT_LINE) ? 8'd0 : line_inc;
    stat     = st.status_word;

    unique case (sts_pkg::sts_kind_t'(item.kind))
      sts_pkg::KIND_WRITE: begin
        st_nxt.status_word = (st.status_word & sts_pkg::KEEP_ON_WRITE) | item.write_value;
      end
      sts_pkg::KIND_BOUNDARY: begin
        if (!st.in_hblank_phase) begin
          // hblank start
          st_nxt.in_hblank_phase = 1'b1;
          stat[sts_pkg::ST_HBLANK] = 1'b1;
          if (st.line_count < VIS_LINE) begin
            res.render_line = (st.skip_countdown == 8'd0);
            res.dma_hblank  = 1'b1;
          end
          res.hblank_irq     = stat[sts_pkg::ST_HBLANK_IE];
          st_nxt.status_word = stat;
        end else begin
          // draw start: advance line, then compare and vblank handling
          st_nxt.in_hblank_phase = 1'b0;
          stat[sts_pkg::ST_HBLANK] = 1'b0;
          st_nxt.line_count = line_new;
          if (line_new == stat[15:8]) begin
            stat[sts_pkg::ST_MATCH] = 1'b1;
            res.irq_line_match      = stat[sts_pkg::ST_MATCH_IE];
          end else begin
            stat[sts_pkg::ST_MATCH] = 1'b0;
          end
          priority if (line_new == 8'd0) begin
            res.frame_start = 1'b1;
          end else if (line_new == VIS_LINE) begin
            stat[sts_pkg::ST_VBLANK] = 1'b1;
            res.finish_frame = (st.skip_countdown == 8'd0);
            res.dma_vblank   = 1'b1;
            res.vblank_irq   = stat[sts_pkg::ST_VBLANK_IE];
            res.frame_end    = 1'b1;
            st_nxt.skip_countdown = (st.skip_countdown == 8'd0) ?
                                    frames_to_skip : st.skip_countdown - 8'd1;
            st_nxt.frames_done = st.frames_done + 32'd1;
          end else if (line_new == LAST_LINE) begin
            stat[sts_pkg::ST_VBLANK] = 1'b0;
          end else begin
            stat = stat;
          end
          st_nxt.status_word = stat;
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase

    res.line         = st_nxt.line_count;
    res.status       = st_nxt.status_word;
    res.frame_number = st_nxt.frames_done;
  end

endmodule
